[design/crts_pkg.sv]
// Shared types, command codes and saturating arithmetic for the clip and transform stack.
package crts_pkg;

	// Command codes
	localparam logic [2:0] ACT_PUSH_CLIP = 3'd0;
	localparam logic [2:0] ACT_POP_CLIP  = 3'd1;
	localparam logic [2:0] ACT_PUSH_XF   = 3'd2;
	localparam logic [2:0] ACT_POP_XF    = 3'd3;
	localparam logic [2:0] ACT_QUERY     = 3'd4;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// Configuration register indexes
	localparam logic [0:0] CFG_VP_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_VP_HEIGHT = 1'b1;

	localparam int CFG_DW = 15;

	localparam logic [CFG_DW-1:0] VP_WIDTH_RST  = 15'd1920;
	localparam logic [CFG_DW-1:0] VP_HEIGHT_RST = 15'd1080;
	localparam logic [7:0]        FULL_OPACITY  = 8'd255;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_bottom;
		logic signed [15:0] shift_x;
		logic signed [15:0] shift_y;
		logic [7:0]         opacity_in;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_top;
		logic signed [15:0] out_right;
		logic signed [15:0] out_bottom;
		logic               scissor_set;
		logic [7:0]         opacity_now;
		logic [1:0]         status;
	} res_t;

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] t;
		logic signed [15:0] r;
		logic signed [15:0] b;
	} rect_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         op;
	} xform_t;

	// Add with clamp to the signed 16-bit range
	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		s = $signed({a[15], a}) + $signed({b[15], b});
		if (s[16] != s[15]) begin
			return s[16] ? 16'sh8000 : 16'sh7fff;
		end
		return s[15:0];
	endfunction

	// Subtract with clamp to the signed 16-bit range
	function automatic logic signed [15:0] sat_sub(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		s = $signed({a[15], a}) - $signed({b[15], b});
		if (s[16] != s[15]) begin
			return s[16] ? 16'sh8000 : 16'sh7fff;
		end
		return s[15:0];
	endfunction

	function automatic logic signed [15:0] smin(input logic signed [15:0] a,
		input logic signed [15:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [15:0] smax(input logic signed [15:0] a,
		input logic signed [15:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

[design/crts_ram.sv]
// Generic single write port RAM with one registered read port.
module crts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one beat, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/clip_rect_transform_stack_core.sv]
// Scissor clip stack and translation/opacity stack, one command per cycle.
//
// Usage:
//   A command beat (cmd) is taken at a rising edge where start is high and
//   busy is low; busy stays low, so a command may be issued every cycle.
//   The command is registered, worked in the next cycle against the stack
//   tops, and its result beat is registered onto result with done high
//   for exactly one cycle. Throughput is one command per cycle. Each
//   command produces one result.
//   The receiver cannot hold results off: a result is valid only in its
//   done cycle. Stack tops live in registers; the entries beneath sit in
//   one RAM per stack, whose read port always prefetches the entry under
//   the top so that back-to-back pops find it ready.
//   Viewport width and height are written through cfg_we/cfg_index/cfg_data
//   while no command is in flight.
//   Reset (arst_n low) empties the clip stack, leaves only the base
//   transform (zero offset, full opacity) and restores the viewport to
//   1920 by 1080. No clearing pass is needed; commands are taken at once.
module clip_rect_transform_stack_core #(
	parameter int CLIP_DEPTH  = 16,
	parameter int XFORM_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  crts_pkg::cmd_t             cmd,
	output logic                       done,
	output crts_pkg::res_t             result,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [crts_pkg::CFG_DW-1:0] cfg_data
);

	localparam int CAW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
	localparam int CCW = $clog2(CLIP_DEPTH + 2);
	localparam int XAW = $clog2(XFORM_DEPTH);
	localparam int XCW = $clog2(XFORM_DEPTH + 2);

	localparam crts_pkg::xform_t XF_BASE = '{x: 16'sd0, y: 16'sd0,
		op: crts_pkg::FULL_OPACITY};

	// Input and result registers
	crts_pkg::cmd_t cmd_s1;
	logic           vld_s1;
	crts_pkg::res_t res_q;
	logic           done_q;
	crts_pkg::res_t res_d;

	// Configuration
	logic [crts_pkg::CFG_DW-1:0] vp_w_q;
	logic [crts_pkg::CFG_DW-1:0] vp_h_q;

	// Stack state
	logic [CCW-1:0]   clip_cnt_q, clip_cnt_d;
	crts_pkg::rect_t  clip_top_q, clip_top_d;
	crts_pkg::rect_t  clip_under;
	logic             clip_we;
	logic [CAW-1:0]   clip_raddr;
	logic [XCW-1:0]   xf_cnt_q, xf_cnt_d;
	crts_pkg::xform_t xf_top_q, xf_top_d;
	crts_pkg::xform_t xf_rd, xf_under;
	logic             xf_we;
	logic [XAW-1:0]   xf_raddr;

	// Datapath terms
	crts_pkg::rect_t  view, cur_clip, tr, isect, push_rect, pop_rect, vis;
	crts_pkg::xform_t xf_new;
	logic             clip_full, xf_full;

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = res_q;

	// Register the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	// Write viewport registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q <= crts_pkg::VP_WIDTH_RST;
			vp_h_q <= crts_pkg::VP_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crts_pkg::CFG_VP_WIDTH:  vp_w_q <= cfg_data;
				crts_pkg::CFG_VP_HEIGHT: vp_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Form rectangle candidates
	always_comb begin
		view.l = 16'sd0;
		view.t = 16'sd0;
		view.r = $signed({1'b0, vp_w_q});
		view.b = $signed({1'b0, vp_h_q});

		cur_clip = (clip_cnt_q != '0) ? clip_top_q : view;

		tr.l = crts_pkg::sat_add(cmd_s1.rect_left,   xf_top_q.x);
		tr.t = crts_pkg::sat_add(cmd_s1.rect_top,    xf_top_q.y);
		tr.r = crts_pkg::sat_add(cmd_s1.rect_right,  xf_top_q.x);
		tr.b = crts_pkg::sat_add(cmd_s1.rect_bottom, xf_top_q.y);

		isect.l = crts_pkg::smin(crts_pkg::smax(clip_top_q.l, tr.l), tr.r);
		isect.t = crts_pkg::smin(crts_pkg::smax(clip_top_q.t, tr.t), tr.b);
		isect.r = crts_pkg::smax(crts_pkg::smin(clip_top_q.r, tr.r), tr.l);
		isect.b = crts_pkg::smax(crts_pkg::smin(clip_top_q.b, tr.b), tr.t);

		push_rect = (clip_cnt_q != '0) ? isect : tr;
		pop_rect  = (clip_cnt_q >= CCW'(2)) ? clip_under : view;

		vis.l = crts_pkg::sat_sub(cur_clip.l, xf_top_q.x);
		vis.t = crts_pkg::sat_sub(cur_clip.t, xf_top_q.y);
		vis.r = crts_pkg::sat_sub(cur_clip.r, xf_top_q.x);
		vis.b = crts_pkg::sat_sub(cur_clip.b, xf_top_q.y);

		xf_new.x  = crts_pkg::sat_add(xf_top_q.x, cmd_s1.shift_x);
		xf_new.y  = crts_pkg::sat_add(xf_top_q.y, cmd_s1.shift_y);
		xf_new.op = cmd_s1.opacity_in;

		xf_under  = (xf_cnt_q == XCW'(2)) ? XF_BASE : xf_rd;
		clip_full = clip_cnt_q >= CCW'(CLIP_DEPTH);
		xf_full   = xf_cnt_q >= XCW'(XFORM_DEPTH);
	end

	// Decode the command, update the stacks and build the result
	always_comb begin
		clip_cnt_d = clip_cnt_q;
		clip_top_d = clip_top_q;
		clip_we    = 1'b0;
		xf_cnt_d   = xf_cnt_q;
		xf_top_d   = xf_top_q;
		xf_we      = 1'b0;
		res_d      = '0;
		res_d.opacity_now = xf_top_q.op;
		res_d.status      = crts_pkg::STAT_OK;
		if (vld_s1) begin
			unique case (cmd_s1.action)
				crts_pkg::ACT_PUSH_CLIP: begin
					if (clip_full) begin
						res_d.status = crts_pkg::STAT_FULL;
					end else begin
						clip_we     = 1'b1;
						clip_cnt_d  = clip_cnt_q + CCW'(1);
						clip_top_d  = push_rect;
						res_d.out_left    = push_rect.l;
						res_d.out_top     = push_rect.t;
						res_d.out_right   = push_rect.r;
						res_d.out_bottom  = push_rect.b;
						res_d.scissor_set = 1'b1;
					end
				end
				crts_pkg::ACT_POP_CLIP: begin
					if (clip_cnt_q == '0) begin
						res_d.status = crts_pkg::STAT_EMPTY;
					end else begin
						clip_cnt_d  = clip_cnt_q - CCW'(1);
						clip_top_d  = clip_under;
						res_d.out_left    = pop_rect.l;
						res_d.out_top     = pop_rect.t;
						res_d.out_right   = pop_rect.r;
						res_d.out_bottom  = pop_rect.b;
						res_d.scissor_set = 1'b1;
					end
				end
				crts_pkg::ACT_PUSH_XF: begin
					if (xf_full) begin
						res_d.status = crts_pkg::STAT_FULL;
					end else begin
						xf_we    = 1'b1;
						xf_cnt_d = xf_cnt_q + XCW'(1);
						xf_top_d = xf_new;
						res_d.opacity_now = xf_new.op;
					end
				end
				crts_pkg::ACT_POP_XF: begin
					if (xf_cnt_q <= XCW'(1)) begin
						res_d.status = crts_pkg::STAT_EMPTY;
					end else begin
						xf_cnt_d = xf_cnt_q - XCW'(1);
						xf_top_d = xf_under;
						res_d.opacity_now = xf_under.op;
					end
				end
				crts_pkg::ACT_QUERY: begin
					res_d.out_left   = vis.l;
					res_d.out_top    = vis.t;
					res_d.out_right  = vis.r;
					res_d.out_bottom = vis.b;
				end
				default: ;
			endcase
		end
	end

	// Prefetch the entry under the next top
	always_comb begin
		clip_raddr = (clip_cnt_d >= CCW'(2)) ? CAW'(clip_cnt_d - CCW'(2)) : '0;
		xf_raddr   = (xf_cnt_d >= XCW'(2)) ? XAW'(xf_cnt_d - XCW'(2)) : '0;
	end

	// Hold stack counts and tops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_cnt_q <= '0;
			xf_cnt_q   <= XCW'(1);
			xf_top_q   <= XF_BASE;
		end else begin
			clip_cnt_q <= clip_cnt_d;
			xf_cnt_q   <= xf_cnt_d;
			xf_top_q   <= xf_top_d;
		end
	end

	always_ff @(posedge clk) begin
		clip_top_q <= clip_top_d;
	end

	// Register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	crts_ram #(
		.WIDTH($bits(crts_pkg::rect_t)),
		.DEPTH(CLIP_DEPTH)
	) u_clip_ram (
		.clk  (clk),
		.we   (clip_we),
		.waddr(clip_cnt_q[CAW-1:0]),
		.wdata(push_rect),
		.raddr(clip_raddr),
		.rdata(clip_under)
	);

	crts_ram #(
		.WIDTH($bits(crts_pkg::xform_t)),
		.DEPTH(XFORM_DEPTH)
	) u_xf_ram (
		.clk  (clk),
		.we   (xf_we),
		.waddr(xf_cnt_q[XAW-1:0]),
		.wdata(xf_new),
		.raddr(xf_raddr),
		.rdata(xf_rd)
	);

endmodule

[design/crts_checker.sv]
// Port-level checker for the clip and transform stack, bound to the top level.
module crts_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input crts_pkg::cmd_t              cmd,
	input logic                        done,
	input crts_pkg::res_t              result
);

	// Every accepted command beat yields a result beat through the command and result registers
	a_cmd_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted command produced no result beat");

	// No result beat without an accepted command behind it
	a_res_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat with no command behind it");

	// A new scissor is never reported together with an ignored command
	a_set_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.scissor_set |-> result.status == crts_pkg::STAT_OK)
		else $error("scissor set on an ignored command");

	// Ignored pushes and pops carry an all-zero rectangle
	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != crts_pkg::STAT_OK |->
		result.out_left == 16'sd0 && result.out_top == 16'sd0 &&
		result.out_right == 16'sd0 && result.out_bottom == 16'sd0)
		else $error("ignored command returned a rectangle");

	// A query never sets a scissor
	a_query_no_set: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cmd.action, 2) == crts_pkg::ACT_QUERY |-> !result.scissor_set)
		else $error("query reported a scissor set");

endmodule

bind clip_rect_transform_stack_core crts_checker u_crts_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.result(result)
);

[sim/testbench.sv]
// Self-checking testbench for the clip rectangle and transform stack core.
module testbench;

	localparam int CLIP_DEPTH  = 16;
	localparam int XFORM_DEPTH = 16;
	localparam int STALL_LIMIT = 1000;
	localparam int PRINT_LIMIT = 50;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        start     = 1'b0;
	logic                        busy;
	crts_pkg::cmd_t              cmd       = '0;
	logic                        done;
	crts_pkg::res_t              result;
	logic                        cfg_we    = 1'b0;
	logic [0:0]                  cfg_index = crts_pkg::CFG_VP_WIDTH;
	logic [crts_pkg::CFG_DW-1:0] cfg_data  = '0;

	clip_rect_transform_stack_core #(
		.CLIP_DEPTH (CLIP_DEPTH),
		.XFORM_DEPTH(XFORM_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of both stacks and the viewport
	crts_pkg::rect_t             clip_mem [CLIP_DEPTH];
	int                          clip_cnt = 0;
	crts_pkg::xform_t            xf_mem [XFORM_DEPTH];
	int                          xf_cnt   = 1;
	logic [crts_pkg::CFG_DW-1:0] vp_w     = crts_pkg::VP_WIDTH_RST;
	logic [crts_pkg::CFG_DW-1:0] vp_h     = crts_pkg::VP_HEIGHT_RST;

	crts_pkg::cmd_t cmd_backlog [$];
	crts_pkg::res_t due_results [$];

	int gap_left     = 0;
	int steady_left  = 0;
	int mismatch_cnt = 0;
	int result_cnt   = 0;
	int idle_cycles  = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic int imin(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Append one command to the pending backlog
	function automatic void add_cmd(input crts_pkg::cmd_t c);
		cmd_backlog.insert(cmd_backlog.size(), c);
	endfunction

	// Apply one command to the shadow stacks and return the beat it should produce
	function automatic crts_pkg::res_t run_stack_cmd(input crts_pkg::cmd_t c);
		crts_pkg::rect_t  vp;
		crts_pkg::rect_t  top;
		crts_pkg::rect_t  r;
		crts_pkg::rect_t  n;
		crts_pkg::rect_t  shown;
		crts_pkg::xform_t tx;
		crts_pkg::xform_t nx;
		crts_pkg::res_t   o;
		o = '0;
		shown = '0;
		vp.l = 16'sd0;
		vp.t = 16'sd0;
		vp.r = {1'b0, vp_w};
		vp.b = {1'b0, vp_h};
		tx = xf_mem[xf_cnt - 1];
		top = (clip_cnt > 0) ? clip_mem[clip_cnt - 1] : vp;
		case (c.action)
		crts_pkg::ACT_PUSH_CLIP: begin
			if (clip_cnt >= CLIP_DEPTH) begin
				o.status = crts_pkg::STAT_FULL;
			end else begin
				r.l = clamp16(int'(c.rect_left) + int'(tx.x));
				r.t = clamp16(int'(c.rect_top) + int'(tx.y));
				r.r = clamp16(int'(c.rect_right) + int'(tx.x));
				r.b = clamp16(int'(c.rect_bottom) + int'(tx.y));
				// Clamp into the current scissor, no check for inverted edges
				if (clip_cnt > 0) begin
					n.l = 16'(imin(imax(int'(top.l), int'(r.l)), int'(r.r)));
					n.t = 16'(imin(imax(int'(top.t), int'(r.t)), int'(r.b)));
					n.r = 16'(imax(imin(int'(top.r), int'(r.r)), int'(r.l)));
					n.b = 16'(imax(imin(int'(top.b), int'(r.b)), int'(r.t)));
					r = n;
				end
				clip_mem[clip_cnt] = r;
				clip_cnt++;
				shown = r;
				o.scissor_set = 1'b1;
			end
		end
		crts_pkg::ACT_POP_CLIP: begin
			if (clip_cnt == 0) begin
				o.status = crts_pkg::STAT_EMPTY;
			end else begin
				clip_cnt--;
				shown = (clip_cnt > 0) ? clip_mem[clip_cnt - 1] : vp;
				o.scissor_set = 1'b1;
			end
		end
		crts_pkg::ACT_PUSH_XF: begin
			if (xf_cnt >= XFORM_DEPTH) begin
				o.status = crts_pkg::STAT_FULL;
			end else begin
				nx.x = clamp16(int'(tx.x) + int'(c.shift_x));
				nx.y = clamp16(int'(tx.y) + int'(c.shift_y));
				nx.op = c.opacity_in;
				xf_mem[xf_cnt] = nx;
				xf_cnt++;
			end
		end
		crts_pkg::ACT_POP_XF: begin
			// The base transform never leaves
			if (xf_cnt <= 1) o.status = crts_pkg::STAT_EMPTY;
			else xf_cnt--;
		end
		crts_pkg::ACT_QUERY: begin
			shown.l = clamp16(int'(top.l) - int'(tx.x));
			shown.t = clamp16(int'(top.t) - int'(tx.y));
			shown.r = clamp16(int'(top.r) - int'(tx.x));
			shown.b = clamp16(int'(top.b) - int'(tx.y));
		end
		default: begin
		end
		endcase
		o.out_left    = shown.l;
		o.out_top     = shown.t;
		o.out_right   = shown.r;
		o.out_bottom  = shown.b;
		o.opacity_now = xf_mem[xf_cnt - 1].op;
		return o;
	endfunction

	function automatic crts_pkg::cmd_t make_cmd(input logic [2:0] act,
		input logic signed [15:0] l, input logic signed [15:0] t,
		input logic signed [15:0] r, input logic signed [15:0] b,
		input logic signed [15:0] sx, input logic signed [15:0] sy, input logic [7:0] op);
		crts_pkg::cmd_t c;
		c.action      = act;
		c.rect_left   = l;
		c.rect_top    = t;
		c.rect_right  = r;
		c.rect_bottom = b;
		c.shift_x     = sx;
		c.shift_y     = sy;
		c.opacity_in  = op;
		return c;
	endfunction

	// Mostly small coordinates, with the range ends and full-range values mixed in
	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 9))
		0: return 16'sh8000;
		1: return 16'sh7fff;
		2, 3: return 16'($urandom);
		default: return 16'($urandom_range(0, 4000)) - 16'sd2000;
		endcase
	endfunction

	// Mostly back to back, some short gaps, a few long ones, now and then a steady run
	function automatic int pick_gap();
		int roll;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			steady_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Queue random commands in bursts that fill, drain or churn the stacks
	task automatic queue_random(input int count);
		int             mode;
		int             roll;
		int             t_pc;
		int             t_px;
		int             t_oc;
		int             t_ox;
		crts_pkg::cmd_t c;
		mode = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0) mode = $urandom_range(0, 2);
			case (mode)
			0: begin t_pc = 35; t_px = 60; t_oc = 68; t_ox = 74; end
			1: begin t_pc = 8;  t_px = 14; t_oc = 45; t_ox = 72; end
			default: begin t_pc = 22; t_px = 44; t_oc = 62; t_ox = 80; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < t_pc) c.action = crts_pkg::ACT_PUSH_CLIP;
			else if (roll < t_px) c.action = crts_pkg::ACT_PUSH_XF;
			else if (roll < t_oc) c.action = crts_pkg::ACT_POP_CLIP;
			else if (roll < t_ox) c.action = crts_pkg::ACT_POP_XF;
			else if (roll < 96) c.action = crts_pkg::ACT_QUERY;
			else c.action = crts_pkg::ACT_QUERY + 3'($urandom_range(1, 3));
			c.rect_left   = rand_coord();
			c.rect_top    = rand_coord();
			c.rect_right  = rand_coord();
			c.rect_bottom = rand_coord();
			c.shift_x     = rand_coord();
			c.shift_y     = rand_coord();
			c.opacity_in  = 8'($urandom_range(0, 255));
			add_cmd(c);
		end
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [crts_pkg::CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Hold until every queued command is taken and every result has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || start || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_fault(input string line);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_LIMIT) $display("%s", line);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_fault($sformatf("result %0d: %s is %h, want %h", result_cnt, name, got, want));
	endtask

	// Driver: predict on each accepted beat, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == crts_pkg::CFG_VP_WIDTH) vp_w = cfg_data;
				else vp_h = cfg_data;
			end
			if (start && !busy) due_results.insert(due_results.size(), run_stack_cmd(cmd));
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd      <= cmd_backlog.pop_front();
					start    <= 1'b1;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		crts_pkg::res_t want;
		if (arst_n && done) begin
			result_cnt++;
			if (due_results.size() == 0) begin
				report_fault($sformatf("result %0d arrived with nothing due", result_cnt));
			end else begin
				want = due_results.pop_front();
				check_field("out_left", result.out_left, want.out_left);
				check_field("out_top", result.out_top, want.out_top);
				check_field("out_right", result.out_right, want.out_right);
				check_field("out_bottom", result.out_bottom, want.out_bottom);
				check_field("scissor_set", 16'(result.scissor_set), 16'(want.scissor_set));
				check_field("opacity_now", 16'(result.opacity_now), 16'(want.opacity_now));
				check_field("status", 16'(result.status), 16'(want.status));
			end
		end
	end

	// Watchdog: stop when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[clip_rect_transform_stack_core] ERROR");
			$finish;
		end
	end

	initial begin
		logic [crts_pkg::CFG_DW-1:0] w;
		logic [crts_pkg::CFG_DW-1:0] h;
		xf_mem[0].x  = 16'sd0;
		xf_mem[0].y  = 16'sd0;
		xf_mem[0].op = crts_pkg::FULL_OPACITY;

		// Directed: empty pops, saturating offsets, inverted and extreme rectangles
		add_cmd(make_cmd(crts_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_POP_CLIP, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_POP_XF, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_PUSH_XF, 0, 0, 0, 0,
			16'sh7fff, 16'sh8000, 8'd0));
		add_cmd(make_cmd(crts_pkg::ACT_PUSH_XF, 0, 0, 0, 0,
			16'sh7fff, 16'sh8000, 8'd255));
		add_cmd(make_cmd(crts_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_PUSH_CLIP, 16'sh8000, 16'sh8000,
			16'sh7fff, 16'sh7fff, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_POP_XF, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_POP_XF, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_PUSH_CLIP, 300, 200, 100, 50, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_PUSH_CLIP, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'shffff, 16'shffff, 8'hff));
		add_cmd(make_cmd(crts_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_QUERY + 3'd1, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_QUERY + 3'd2, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_QUERY + 3'd3, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_PUSH_XF, 0, 0, 0, 0, -100, 50, 8'd128));
		add_cmd(make_cmd(crts_pkg::ACT_PUSH_CLIP, 0, 0, 640, 480, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0));
		repeat (5) add_cmd(make_cmd(crts_pkg::ACT_POP_CLIP, 0, 0, 0, 0, 0, 0, 0));
		add_cmd(make_cmd(crts_pkg::ACT_POP_XF, 0, 0, 0, 0, 0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// Random phases, each under its own viewport
		for (int ph = 0; ph < 6; ph++) begin
			w = 15'($urandom);
			h = 15'($urandom);
			case (ph)
			1: begin w = '1; h = '1; end
			2: begin w = 15'd1; h = 15'd1; end
			3: begin w = '0; h = '0; end
			5: begin w = '1; h = 15'd1; end
			default: begin
			end
			endcase
			if (ph != 0) begin
				write_reg(crts_pkg::CFG_VP_WIDTH, w);
				write_reg(crts_pkg::CFG_VP_HEIGHT, h);
			end
			@(negedge clk);
			queue_random(155);
			wait_drained();
		end

		if (mismatch_cnt == 0) $display("[clip_rect_transform_stack_core] OK");
		else $display("[clip_rect_transform_stack_core] ERROR");
		$finish;
	end

endmodule
